// ===== design/rectangle_region_table_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Rectangle region table: assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_REGION_TABLE_UNIT_DEFINES_SVH
`define RECTANGLE_REGION_TABLE_UNIT_DEFINES_SVH

// property holds at every edge
`define RRT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// consequent holds at the clock edge after the antecedent
`define RRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Rectangle region table package
// Sizes, codes, entry and result types, and the overlap function.
// ----------------------------------------------------------------------------
package rrt_pkg;

   localparam int MAX_RECTS  = 32;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_RECTS);
   localparam int CNT_W      = $clog2(MAX_RECTS + 1);
   localparam int RC_W       = 6;
   localparam int AW         = COORD_BITS + 2;
   localparam int ENT_W      = 2 * COORD_BITS + 2 * (COORD_BITS - 1);

   localparam logic signed [AW-1:0] CMAX = AW'(2 ** (COORD_BITS - 1) - 1);
   localparam logic signed [AW-1:0] LIM  = AW'(2 ** COORD_BITS - 1);

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_DEL   = 3'd1,
      OP_SUB   = 3'd2,
      OP_INT   = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      RS_DONE  = 2'd0,
      RS_NOCHG = 2'd1,
      RS_FULL  = 2'd2
   } stat_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISP, ST_APP_RD, ST_APP_CHK, ST_DEL_RD, ST_DEL_CHK,
      ST_RM_RD, ST_RM_WR, ST_SUB_RD, ST_SUB_CHK, ST_SUB_PC, ST_SUB_NX,
      ST_INT_RD, ST_INT_CHK, ST_INT_DRD, ST_INT_DCHK, ST_INT_EMIT, ST_INT_END,
      ST_FIN, ST_EXT_RD, ST_EXT_ACC, ST_EXT_DONE, ST_OUT
   } state_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-2:0] w;
      logic [COORD_BITS-2:0] h;
   } ent_type;

   typedef struct packed {
      op_type                op;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } qry_type;

   typedef struct packed {
      logic    hit;
      ent_type o;
   } ovl_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } ext_type;

   typedef struct packed {
      stat_type         status;
      logic             piece_valid;
      ent_type          piece;
      logic             last;
      logic [RC_W-1:0]  rect_count;
      ext_type          ext;
   } res_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      ent_type          wr_data;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic clr;
      logic acc;
   } ext_ctl_type;

   function automatic ovl_type rrt_overlap(ent_type e, qry_type q);
      logic signed [AW-1:0] ex, ey, ew, eh, qx, qy, qw, qh, l, t, r, b, ow, oh;
      ovl_type res;
      ex = AW'($signed(e.x));
      ey = AW'($signed(e.y));
      ew = $signed(AW'(e.w));
      eh = $signed(AW'(e.h));
      qx = AW'($signed(q.x));
      qy = AW'($signed(q.y));
      qw = AW'($signed(q.w));
      qh = AW'($signed(q.h));
      l  = (ex > qx) ? ex : qx;
      t  = (ey > qy) ? ey : qy;
      r  = (ex + ew < qx + qw) ? ex + ew : qx + qw;
      b  = (ey + eh < qy + qh) ? ey + eh : qy + qh;
      ow = r - l;
      oh = b - t;
      res.hit = (l < r) && (t < b);
      res.o.x = l[COORD_BITS-1:0];
      res.o.y = t[COORD_BITS-1:0];
      res.o.w = ow[COORD_BITS-2:0];
      res.o.h = oh[COORD_BITS-2:0];
      return res;
   endfunction

endpackage

// ===== design/rrt_store.sv =====
// ----------------------------------------------------------------------------
// Rectangle table store
// One write port, one registered read port, one entry per rectangle.
// ----------------------------------------------------------------------------
module rrt_store import rrt_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem,
   output ent_type     rd_data
);

   logic [ENT_W-1:0] mem_ff [MAX_RECTS];
   logic [ENT_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (mem.wr_en) begin
         mem_ff[mem.wr_addr] <= mem.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem_ff[mem.rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// ===== design/rrt_ext.sv =====
// ----------------------------------------------------------------------------
// Rectangle table extents accumulator
// Folds entries into a bounding box, saturating width and height.
// ----------------------------------------------------------------------------
module rrt_ext import rrt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ext_ctl_type ctl,
   input  ent_type     ent,
   output ext_type     ext
);

   logic signed [AW-1:0] lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;
   logic signed [AW-1:0] lo_x_in, lo_y_in, hi_x_in, hi_y_in;
   logic                 any_ff, any_in;
   logic signed [AW-1:0] ex, ey, er, eb, dw, dh;

   always_comb begin
      ex = AW'($signed(ent.x));
      ey = AW'($signed(ent.y));
      er = ex + $signed(AW'(ent.w));
      eb = ey + $signed(AW'(ent.h));
      lo_x_in = lo_x_ff;
      lo_y_in = lo_y_ff;
      hi_x_in = hi_x_ff;
      hi_y_in = hi_y_ff;
      any_in  = any_ff;
      if (ctl.clr) begin
         any_in = 1'b0;
      end else if (ctl.acc) begin
         any_in  = 1'b1;
         lo_x_in = (!any_ff || ex < lo_x_ff) ? ex : lo_x_ff;
         lo_y_in = (!any_ff || ey < lo_y_ff) ? ey : lo_y_ff;
         hi_x_in = (!any_ff || er > hi_x_ff) ? er : hi_x_ff;
         hi_y_in = (!any_ff || eb > hi_y_ff) ? eb : hi_y_ff;
      end
      dw = hi_x_ff - lo_x_ff;
      dh = hi_y_ff - lo_y_ff;
      if (any_ff) begin
         ext.x = lo_x_ff[COORD_BITS-1:0];
         ext.y = lo_y_ff[COORD_BITS-1:0];
         ext.w = (dw > LIM) ? LIM[COORD_BITS-1:0] : dw[COORD_BITS-1:0];
         ext.h = (dh > LIM) ? LIM[COORD_BITS-1:0] : dh[COORD_BITS-1:0];
      end else begin
         ext = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= 1'b0;
      end else begin
         any_ff <= any_in;
      end
      lo_x_ff <= lo_x_in;
      lo_y_ff <= lo_y_in;
      hi_x_ff <= hi_x_in;
      hi_y_ff <= hi_y_in;
   end

endmodule

// ===== design/rrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rectangle table sequencer
// Walks the table through the store's read port for every request type.
// ----------------------------------------------------------------------------
module rrt_ctrl import rrt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_type,
   input  logic [COORD_BITS-1:0] req_rect_x,
   input  logic [COORD_BITS-1:0] req_rect_y,
   input  logic [COORD_BITS-1:0] req_rect_w,
   input  logic [COORD_BITS-1:0] req_rect_h,
   output mem_req_type           mem,
   input  ent_type               rd_data,
   output ext_ctl_type           ext_ctl,
   input  ext_type               ext_val,
   input  logic                  out_free,
   output logic                  push,
   output res_type               res
);

`include "rectangle_region_table_unit_defines.svh"

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, i_ff, i_in, j_ff, j_in, jn;
   logic [1:0]       k_ff, k_in;
   stat_type         status_ff, status_in;
   qry_type          q_ff, q_in;
   ent_type          e_ff, e_in, t_ff, t_in, p_ff, p_in, hold_ff, hold_in;
   ent_type          cand_ff, cand_in, qent;
   logic             have_ff, have_in;
   ext_type          ext_ff, ext_in;
   ovl_type          ov;
   logic signed [AW-1:0] x0, y0, w0, h0, tx, ty, tw, th, px, py, pw, ph;
   logic             qempty, full, skip;

   always_comb begin
      ov     = rrt_overlap(rd_data, q_ff);
      qent   = '{x: q_ff.x, y: q_ff.y, w: q_ff.w[COORD_BITS-2:0],
                 h: q_ff.h[COORD_BITS-2:0]};
      qempty = q_ff.w[COORD_BITS-1] || (q_ff.w == '0) ||
               q_ff.h[COORD_BITS-1] || (q_ff.h == '0);
      full   = (count_ff == CNT_W'(MAX_RECTS));
      jn     = j_ff + CNT_W'(1);
      x0 = AW'($signed(e_ff.x));
      y0 = AW'($signed(e_ff.y));
      w0 = $signed(AW'(e_ff.w));
      h0 = $signed(AW'(e_ff.h));
      tx = AW'($signed(t_ff.x));
      ty = AW'($signed(t_ff.y));
      tw = $signed(AW'(t_ff.w));
      th = $signed(AW'(t_ff.h));
      case (k_ff)
         2'd0: begin
            px = x0;      py = y0;      pw = tx - x0;             ph = h0;
         end
         2'd1: begin
            px = tx;      py = y0;      pw = tw;                  ph = ty - y0;
         end
         2'd2: begin
            px = tx + tw; py = y0;      pw = x0 + w0 - (tx + tw); ph = h0;
         end
         default: begin
            px = tx;      py = ty + th; pw = tw;                  ph = y0 + h0 - (ty + th);
         end
      endcase
      skip = (px > CMAX) || (py > CMAX) || (pw <= AW'(0)) || (ph <= AW'(0));
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      status_in = status_ff;
      q_in      = q_ff;
      e_in      = e_ff;
      t_in      = t_ff;
      p_in      = p_ff;
      hold_in   = hold_ff;
      cand_in   = cand_ff;
      have_in   = have_ff;
      ext_in    = ext_ff;
      req_ready = 1'b0;
      push      = 1'b0;
      mem.wr_en   = 1'b0;
      mem.wr_addr = j_ff[IDX_W-1:0];
      mem.wr_data = rd_data;
      mem.rd_addr = i_ff[IDX_W-1:0];
      ext_ctl.clr = 1'b0;
      ext_ctl.acc = 1'b0;
      res.status      = status_ff;
      res.piece_valid = 1'b0;
      res.piece       = '0;
      res.last        = 1'b1;
      res.rect_count  = RC_W'(count_ff);
      res.ext         = ext_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               q_in     = '{op: op_type'(req_type), x: req_rect_x, y: req_rect_y,
                            w: req_rect_w, h: req_rect_h};
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            i_in = '0;
            j_in = '0;
            case (q_ff.op)
               OP_ADD: begin
                  if (qempty) begin
                     status_in = RS_NOCHG;
                     state_in  = ST_FIN;
                  end else begin
                     cand_in  = qent;
                     state_in = ST_APP_RD;
                  end
               end
               OP_DEL: state_in = ST_DEL_RD;
               OP_SUB: begin
                  status_in = RS_NOCHG;
                  state_in  = ST_SUB_RD;
               end
               OP_INT: begin
                  have_in  = 1'b0;
                  state_in = ST_INT_RD;
               end
               OP_CLEAR: begin
                  count_in  = '0;
                  status_in = RS_DONE;
                  state_in  = ST_FIN;
               end
               default: begin
                  status_in = RS_NOCHG;
                  state_in  = ST_FIN;
               end
            endcase
         end
         ST_APP_RD: begin
            mem.rd_addr = j_ff[IDX_W-1:0];
            if (j_ff == count_ff) begin
               if (full) begin
                  status_in = RS_FULL;
                  state_in  = ST_FIN;
               end else begin
                  mem.wr_en   = 1'b1;
                  mem.wr_addr = count_ff[IDX_W-1:0];
                  mem.wr_data = cand_ff;
                  count_in    = count_ff + CNT_W'(1);
                  if (q_ff.op == OP_ADD) begin
                     status_in = RS_DONE;
                     state_in  = ST_FIN;
                  end else begin
                     state_in = ST_SUB_NX;
                  end
               end
            end else begin
               state_in = ST_APP_CHK;
            end
         end
         ST_APP_CHK: begin
            if (rd_data == cand_ff) begin
               if (q_ff.op == OP_ADD) begin
                  status_in = RS_NOCHG;
                  state_in  = ST_FIN;
               end else begin
                  state_in = ST_SUB_NX;
               end
            end else begin
               j_in     = jn;
               state_in = ST_APP_RD;
            end
         end
         ST_DEL_RD: begin
            if (i_ff == count_ff) begin
               status_in = RS_NOCHG;
               state_in  = ST_FIN;
            end else begin
               state_in = ST_DEL_CHK;
            end
         end
         ST_DEL_CHK: begin
            if (rd_data == qent && !qempty) begin
               j_in     = i_ff;
               state_in = ST_RM_RD;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_DEL_RD;
            end
         end
         ST_RM_RD: begin
            mem.rd_addr = jn[IDX_W-1:0];
            if (jn >= count_ff) begin
               count_in  = count_ff - CNT_W'(1);
               status_in = RS_DONE;
               state_in  = (q_ff.op == OP_SUB) ? ST_SUB_RD : ST_FIN;
            end else begin
               state_in = ST_RM_WR;
            end
         end
         ST_RM_WR: begin
            mem.wr_en = 1'b1;
            j_in      = jn;
            state_in  = ST_RM_RD;
         end
         ST_SUB_RD: begin
            state_in = (i_ff == count_ff) ? ST_FIN : ST_SUB_CHK;
         end
         ST_SUB_CHK: begin
            if (ov.hit) begin
               e_in     = rd_data;
               t_in     = ov.o;
               k_in     = '0;
               state_in = ST_SUB_PC;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_SUB_RD;
            end
         end
         ST_SUB_PC: begin
            if (skip) begin
               state_in = ST_SUB_NX;
            end else begin
               cand_in  = '{x: px[COORD_BITS-1:0], y: py[COORD_BITS-1:0],
                            w: pw[COORD_BITS-2:0], h: ph[COORD_BITS-2:0]};
               j_in     = '0;
               state_in = ST_APP_RD;
            end
         end
         ST_SUB_NX: begin
            if (k_ff == 2'd3) begin
               j_in     = i_ff;
               state_in = ST_RM_RD;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_SUB_PC;
            end
         end
         ST_INT_RD: begin
            state_in = (i_ff == count_ff) ? ST_INT_END : ST_INT_CHK;
         end
         ST_INT_CHK: begin
            if (ov.hit) begin
               p_in     = ov.o;
               j_in     = '0;
               state_in = ST_INT_DRD;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_INT_RD;
            end
         end
         ST_INT_DRD: begin
            mem.rd_addr = j_ff[IDX_W-1:0];
            state_in    = (j_ff == i_ff) ? ST_INT_EMIT : ST_INT_DCHK;
         end
         ST_INT_DCHK: begin
            if (ov.hit && ov.o == p_ff) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_INT_RD;
            end else begin
               j_in     = jn;
               state_in = ST_INT_DRD;
            end
         end
         ST_INT_EMIT: begin
            res.status      = RS_DONE;
            res.piece_valid = 1'b1;
            res.piece       = hold_ff;
            res.last        = 1'b0;
            if (!have_ff || out_free) begin
               push     = have_ff;
               hold_in  = p_ff;
               have_in  = 1'b1;
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_INT_RD;
            end
         end
         ST_INT_END: begin
            res.status      = RS_DONE;
            res.piece_valid = 1'b1;
            res.piece       = hold_ff;
            if (!have_ff) begin
               status_in = RS_NOCHG;
               state_in  = ST_FIN;
            end else if (out_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FIN: begin
            ext_ctl.clr = 1'b1;
            i_in        = '0;
            state_in    = ST_EXT_RD;
         end
         ST_EXT_RD: begin
            state_in = (i_ff == count_ff) ? ST_EXT_DONE : ST_EXT_ACC;
         end
         ST_EXT_ACC: begin
            ext_ctl.acc = 1'b1;
            i_in        = i_ff + CNT_W'(1);
            state_in    = ST_EXT_RD;
         end
         ST_EXT_DONE: begin
            ext_in   = ext_val;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         have_ff  <= 1'b0;
         ext_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         have_ff  <= have_in;
         ext_ff   <= ext_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      q_ff      <= q_in;
      e_ff      <= e_in;
      t_ff      <= t_in;
      p_ff      <= p_in;
      hold_ff   <= hold_in;
      cand_ff   <= cand_in;
   end

   `RRT_ASSERT(a_count_max, count_ff <= CNT_W'(MAX_RECTS), "entry count above table size")
   `RRT_ASSERT(a_push_free, push |-> out_free, "item pushed into a full output stage")
   `RRT_ASSERT(a_wr_range, mem.wr_en |-> (CNT_W'(mem.wr_addr) <= count_ff),
      "table write beyond the fill level")
   `RRT_ASSERT_NEXT(a_last_idle, push && res.last, state_ff == ST_IDLE,
      "final item not followed by idle")

endmodule

// ===== design/rectangle_region_table_unit.sv =====
// ----------------------------------------------------------------------------
// Rectangle region table unit
// Clip region kept as an ordered rectangle table plus bounding extents.
// ----------------------------------------------------------------------------
// Requests enter on the req_ channel (valid/ready): add, delete, subtract,
// intersect or clear, with one rectangle. Results leave on the rsp_ channel
// (valid/ready) through a one-item output register. Intersect returns one
// item per distinct overlap piece in table order, or one item with no
// piece if none, last set on the final one; every other request returns
// a single item. Items carry the entry count and extents after the request.
// One request is processed at a time; req_ready is high only in idle, so a
// new item is taken the cycle after the previous result enters the output
// register. Add scans the table for a duplicate; delete scans it and
// compacts the entries after the match; both then run an extents pass over
// the table, and clear runs that pass alone. Intersect checks each hit
// against all earlier entries; subtract scans the table for each of up to
// four pieces per hit. All table accesses go through the single read port
// of the table store.
// Reset empties the table and zeroes the extents; the store itself is
// not cleared. A stalled receiver holds the result and the sequencer
// waits on it before the next item.
// ----------------------------------------------------------------------------
module rectangle_region_table_unit import rrt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_type,
   input  logic [COORD_BITS-1:0] req_rect_x,
   input  logic [COORD_BITS-1:0] req_rect_y,
   input  logic [COORD_BITS-1:0] req_rect_w,
   input  logic [COORD_BITS-1:0] req_rect_h,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic                  rsp_piece_valid,
   output logic [COORD_BITS-1:0] rsp_piece_x,
   output logic [COORD_BITS-1:0] rsp_piece_y,
   output logic [COORD_BITS-2:0] rsp_piece_w,
   output logic [COORD_BITS-2:0] rsp_piece_h,
   output logic                  rsp_last,
   output logic [RC_W-1:0]       rsp_rect_count,
   output logic [COORD_BITS-1:0] rsp_ext_x,
   output logic [COORD_BITS-1:0] rsp_ext_y,
   output logic [COORD_BITS-1:0] rsp_ext_w,
   output logic [COORD_BITS-1:0] rsp_ext_h
);

   mem_req_type mem;
   ent_type     rd_data;
   ext_ctl_type ext_ctl;
   ext_type     ext_val;
   logic        out_free, push;
   res_type     res, res_ff, res_in;
   logic        valid_ff, valid_in;

   rrt_store u_store (
      .clock   (clock),
      .mem     (mem),
      .rd_data (rd_data)
   );

   rrt_ext u_ext (
      .clock (clock),
      .reset (reset),
      .ctl   (ext_ctl),
      .ent   (rd_data),
      .ext   (ext_val)
   );

   rrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_type   (req_type),
      .req_rect_x (req_rect_x),
      .req_rect_y (req_rect_y),
      .req_rect_w (req_rect_w),
      .req_rect_h (req_rect_h),
      .mem        (mem),
      .rd_data    (rd_data),
      .ext_ctl    (ext_ctl),
      .ext_val    (ext_val),
      .out_free   (out_free),
      .push       (push),
      .res        (res)
   );

   always_comb begin
      out_free = !valid_ff || rsp_ready;
      valid_in = valid_ff && !rsp_ready;
      res_in   = res_ff;
      if (push) begin
         valid_in = 1'b1;
         res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = res_ff.status;
   assign rsp_piece_valid = res_ff.piece_valid;
   assign rsp_piece_x     = res_ff.piece.x;
   assign rsp_piece_y     = res_ff.piece.y;
   assign rsp_piece_w     = res_ff.piece.w;
   assign rsp_piece_h     = res_ff.piece.h;
   assign rsp_last        = res_ff.last;
   assign rsp_rect_count  = res_ff.rect_count;
   assign rsp_ext_x       = res_ff.ext.x;
   assign rsp_ext_y       = res_ff.ext.y;
   assign rsp_ext_w       = res_ff.ext.w;
   assign rsp_ext_h       = res_ff.ext.h;

endmodule
